// ===== sv/atpr_pkg.sv =====
// atpr_pkg: widths, matrix coefficients, curve constants and register reset
// values for the ACES fitted tone mapper with RGBA8 packing.
// No dependencies; imported by the core and its checker.
package atpr_pkg;

    // fixed field and register widths
    localparam int PIX_W       = 16;
    localparam int LEVEL_W     = 3;
    localparam int SCALE_W     = 16;
    localparam int NUM_SCALES  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int RGBA_W      = 32;
    localparam int DEF_LEVELS  = 8;

    // internal widths
    localparam int S_W         = 21;   // scaled channel, Q16, below 2^21
    localparam int M_W         = 21;   // input matrix result, Q16
    localparam int MA_W        = 22;   // m + A
    localparam int SQ_W        = 43;   // m * (m + A), Q32
    localparam int CM_W        = 37;   // C * m
    localparam int T_W         = 22;   // C*m/2^16 + D
    localparam int NUM_W       = 44;   // signed numerator, Q32
    localparam int MAG_W       = 43;   // numerator magnitude
    localparam int DEN_W       = 44;   // denominator, Q32
    localparam int REM_W       = 59;   // dividend magnitude * 2^16
    localparam int CMP_W       = 60;   // shifted denominator compare width
    localparam int Q_W         = 17;   // quotient magnitude
    localparam int DIV_STEPS   = 17;   // one quotient bit per stage
    localparam int Y_W         = 18;   // signed curve output, Q16
    localparam int INP_W       = 37;   // input matrix product
    localparam int INACC_W     = 39;   // input matrix sum
    localparam int OUTP_W      = 36;   // output matrix product
    localparam int OUTACC_W    = 38;   // output matrix sum
    localparam int BYTE_W      = 8;

    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic [SCALE_W-1:0]        scale_t;
    typedef logic [S_W-1:0]            chan_s_t;
    typedef logic [M_W-1:0]            chan_m_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic [DEN_W-1:0]          den_t;
    typedef logic [REM_W-1:0]          rem_t;
    typedef logic [Q_W-1:0]            quot_t;
    typedef logic signed [Y_W-1:0]     chan_y_t;

    // curve constants
    localparam logic [10:0] CURVE_A = 11'd1611;
    localparam num_t        CURVE_B = 44'sd388853;
    localparam logic [15:0] CURVE_C = 16'd64470;
    localparam logic [14:0] CURVE_D = 15'd28374;
    localparam den_t        CURVE_E = 44'd1022550109;

    // ACES input matrix, Q16
    localparam logic [15:0] MAT_IN [9] = '{
        16'd39137, 16'd23238, 16'd3161,
        16'd4981,  16'd59529, 16'd1026,
        16'd1861,  16'd8771,  16'd54904
    };

    // ACES output matrix, signed Q16
    localparam logic signed [17:0] MAT_OUT [9] = '{
        18'sd105169, -18'sd34805, -18'sd4828,
        -18'sd6690,  18'sd72622,  -18'sd396,
        -18'sd214,   -18'sd4768,  18'sd70518
    };

    localparam scale_t SCALE_RESET [NUM_SCALES] = '{
        16'd32768, 16'd22938, 16'd16384, 16'd9830,
        16'd32768, 16'd32768, 16'd32768, 16'd32768
    };

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

endpackage

// ===== sv/aces_tonemap_pack_rgba_core.sv =====
// aces_tonemap_pack_rgba_core: pipelined ACES fitted tone mapper that packs
// the result as RGBA8. Depends on atpr_pkg.

// One pixel enters per clock cycle while s_ready is high. The pipeline
// runs as one unit: when the output register holds a pixel that is not
// taken, every stage holds and s_ready drops, so the rate is one pixel
// per cycle whenever m_ready is high. The depth is set by the curve
// division, a restoring divider with one quotient bit per stage over
// 17 stages, plus eleven stages of scaling, matrices, curve terms and
// packing. The post scale registers are written through cfg_we, cfg_index
// and cfg_wdata; writes to an index at or above LEVELS are dropped, and a
// level at or above LEVELS uses the last level's scale.
module aces_tonemap_pack_rgba_core #(
    parameter int LEVELS = atpr_pkg::DEF_LEVELS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [atpr_pkg::PIX_W-1:0]     s_red,
    input  logic [atpr_pkg::PIX_W-1:0]     s_green,
    input  logic [atpr_pkg::PIX_W-1:0]     s_blue,
    input  logic [atpr_pkg::LEVEL_W-1:0]   s_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [atpr_pkg::RGBA_W-1:0]    m_rgba,
    input  logic                           cfg_we,
    input  logic [atpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atpr_pkg::SCALE_W-1:0]   cfg_wdata
);
    import atpr_pkg::*;

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NST   = 11 + DIV_STEPS;
    localparam int DIV0  = 7;   // valid index of the first divider stage

    // global advance: everything moves unless the output is held
    logic adv;
    logic [NST-1:0] vld_reg, vld_next;

    assign adv     = !vld_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];

    always_comb begin
        vld_next = {vld_reg[NST-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // post scale registers
    scale_t scale_reg [LEVELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                scale_reg[i] <= SCALE_RESET[i];
            end
        end else if (cfg_we && (int'(cfg_index) < LEVELS)) begin
            scale_reg[cfg_index[LVL_W-1:0]] <= cfg_wdata;
        end
    end

    // stage 1: level select and brightness scale
    logic [LVL_W-1:0]  lvl_idx;
    scale_t            scale_sel;
    pix_t              pix [3];
    logic [31:0]       sprod [3];
    chan_s_t           s1_next [3];
    chan_s_t           s1_reg [3];

    always_comb begin
        if (int'(s_level) >= LEVELS) begin
            lvl_idx = LVL_W'(LEVELS - 1);
        end else begin
            lvl_idx = s_level[LVL_W-1:0];
        end
        scale_sel = scale_reg[lvl_idx];
        pix[0] = s_red;
        pix[1] = s_green;
        pix[2] = s_blue;
        for (int c = 0; c < 3; c++) begin
            sprod[c]   = 32'(pix[c]) * 32'(scale_sel);
            s1_next[c] = sprod[c][31:11];
        end
    end

    // stage 2: input matrix products
    logic [INP_W-1:0] p2_reg [9];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    p2_reg[r*3+c] <= INP_W'(s1_reg[c]) * INP_W'(MAT_IN[r*3+c]);
                end
            end
        end
    end

    // stage 3: input matrix sums
    logic [INACC_W-1:0] inacc [3];
    chan_m_t            m3_reg [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            inacc[r] = INACC_W'(p2_reg[r*3]) + INACC_W'(p2_reg[r*3+1])
                     + INACC_W'(p2_reg[r*3+2]);
        end
    end

    // stages 4 to 7: curve numerator and denominator
    logic [MA_W-1:0]  ma [3];
    logic [SQ_W-1:0]  sq4_reg [3];
    logic [CM_W-1:0]  cm4_reg [3];
    chan_m_t          m4_reg [3];
    num_t             num5_reg [3];
    logic [T_W-1:0]   t5_reg [3];
    chan_m_t          m5_reg [3];
    logic [SQ_W-1:0]  mt6_reg [3];
    num_t             num6_reg [3];
    num_t             num_neg [3];
    logic [MAG_W-1:0] mag [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ma[c]      = MA_W'(m3_reg[c]) + MA_W'(CURVE_A);
            num_neg[c] = -num6_reg[c];
            mag[c]     = num6_reg[c][NUM_W-1] ? num_neg[c][MAG_W-1:0]
                                              : num6_reg[c][MAG_W-1:0];
        end
    end

    // divider stage registers; index 0 is the register loaded in stage 7
    rem_t  rem_reg [DIV_STEPS+1][3];
    quot_t q_reg   [DIV_STEPS+1][3];
    den_t  den_reg [DIV_STEPS+1][3];
    logic  neg_reg [DIV_STEPS+1][3];

    rem_t              rem_next [DIV_STEPS][3];
    quot_t             q_next   [DIV_STEPS][3];
    logic [CMP_W-1:0]  dsh      [DIV_STEPS][3];
    logic              ge       [DIV_STEPS][3];

    // one restoring step per stage, most significant quotient bit first
    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int c = 0; c < 3; c++) begin
                dsh[j][c] = CMP_W'(den_reg[j][c]) << (DIV_STEPS - 1 - j);
                ge[j][c]  = CMP_W'(rem_reg[j][c]) >= dsh[j][c];
                rem_next[j][c] = ge[j][c] ? rem_reg[j][c] - dsh[j][c][REM_W-1:0]
                                          : rem_reg[j][c];
                q_next[j][c] = {q_reg[j][c][Q_W-2:0], ge[j][c]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                m3_reg[c]   <= inacc[c][M_W+15:16];
                sq4_reg[c]  <= SQ_W'(m3_reg[c]) * SQ_W'(ma[c]);
                cm4_reg[c]  <= CM_W'(m3_reg[c]) * CM_W'(CURVE_C);
                m4_reg[c]   <= m3_reg[c];
                num5_reg[c] <= $signed({1'b0, sq4_reg[c]}) - CURVE_B;
                t5_reg[c]   <= T_W'(cm4_reg[c][CM_W-1:16]) + T_W'(CURVE_D);
                m5_reg[c]   <= m4_reg[c];
                mt6_reg[c]  <= SQ_W'(m5_reg[c]) * SQ_W'(t5_reg[c]);
                num6_reg[c] <= num5_reg[c];
                rem_reg[0][c] <= {mag[c], 16'd0};
                q_reg[0][c]   <= '0;
                den_reg[0][c] <= DEN_W'(mt6_reg[c]) + CURVE_E;
                neg_reg[0][c] <= num6_reg[c][NUM_W-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int c = 0; c < 3; c++) begin
                    rem_reg[j+1][c] <= rem_next[j][c];
                    q_reg[j+1][c]   <= q_next[j][c];
                    den_reg[j+1][c] <= den_reg[j][c];
                    neg_reg[j+1][c] <= neg_reg[j][c];
                end
            end
        end
    end

    // sign restore, output matrix, clamp and pack
    chan_y_t                     y_next [3];
    chan_y_t                     y_reg [3];
    logic signed [OUTP_W-1:0]    op_reg [9];
    logic signed [OUTACC_W-1:0]  oacc_next [3];
    logic signed [OUTACC_W-1:0]  oacc_reg [3];
    logic [BYTE_W-1:0]           byte_next [3];
    logic [RGBA_W-1:0]           rgba_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (neg_reg[DIV_STEPS][c]) begin
                y_next[c] = -$signed({1'b0, q_reg[DIV_STEPS][c]});
            end else begin
                y_next[c] = $signed({1'b0, q_reg[DIV_STEPS][c]});
            end
            oacc_next[c] = OUTACC_W'(op_reg[c*3]) + OUTACC_W'(op_reg[c*3+1])
                         + OUTACC_W'(op_reg[c*3+2]);
            if (oacc_reg[c] <= 0) begin
                byte_next[c] = '0;
            end else if (oacc_reg[c][OUTACC_W-1:32] != '0) begin
                byte_next[c] = 8'hFF;
            end else begin
                byte_next[c] = oacc_reg[c][31:24];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg <= y_next;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    op_reg[r*3+c] <= OUTP_W'(y_reg[c]) * OUTP_W'(MAT_OUT[r*3+c]);
                end
            end
            oacc_reg <= oacc_next;
            rgba_reg <= {ALPHA_OPAQUE, byte_next[2], byte_next[1], byte_next[0]};
        end
    end

    assign m_rgba = rgba_reg;

endmodule

// ===== sv/atpr_checker.sv =====
// atpr_checker: port-level assertions for the tone mapper core, bound to
// the core module. Depends on atpr_pkg.
module atpr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [atpr_pkg::PIX_W-1:0]     s_red,
    input logic [atpr_pkg::PIX_W-1:0]     s_green,
    input logic [atpr_pkg::PIX_W-1:0]     s_blue,
    input logic [atpr_pkg::LEVEL_W-1:0]   s_level,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [atpr_pkg::RGBA_W-1:0]    m_rgba,
    input logic                           cfg_we,
    input logic [atpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [atpr_pkg::SCALE_W-1:0]   cfg_wdata
);
    import atpr_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rgba))
        else $error("result changed while stalled");

    // every result is opaque
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rgba[31:24] == ALPHA_OPAQUE)
        else $error("alpha byte not opaque");

    // a stalled output stalls the input side
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind aces_tonemap_pack_rgba_core atpr_checker u_atpr_checker (.*);
